[hw/rtl/dd_odo_pkg.sv]
package dd_odo_pkg;

   localparam int CORDIC_STEPS_DEF = 24;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 40;

   localparam logic [CSR_IDX_W-1:0] CSR_LEFT_DIST  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RIGHT_DIST = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_YAW_GAIN   = 2'd2;

   localparam int CNT_W = 6;

   localparam logic signed [32:0] UNWRAP_LIMIT = 33'sd1048576000;
   localparam logic signed [33:0] CORDIC_GAIN  = 34'sd652032874;
   localparam logic signed [33:0] Q30_ONE      = 34'sd1073741824;
   localparam logic signed [51:0] POS_MAX      = 52'sd140737488355327;
   localparam logic signed [51:0] POS_MIN      = -52'sd140737488355328;

   function automatic logic [31:0] atan_entry(input logic [4:0] idx);
      logic [31:0] v;
      case (idx)
         5'd0:  v = 32'h20000000;
         5'd1:  v = 32'h12E4051D;
         5'd2:  v = 32'h09FB385B;
         5'd3:  v = 32'h051111D4;
         5'd4:  v = 32'h028B0D43;
         5'd5:  v = 32'h0145D7E1;
         5'd6:  v = 32'h00A2F61E;
         5'd7:  v = 32'h00517C55;
         5'd8:  v = 32'h0028BE53;
         5'd9:  v = 32'h00145F2E;
         5'd10: v = 32'h000A2F98;
         5'd11: v = 32'h000517CC;
         5'd12: v = 32'h00028BE6;
         5'd13: v = 32'h000145F3;
         5'd14: v = 32'h0000A2F9;
         5'd15: v = 32'h0000517C;
         5'd16: v = 32'h000028BE;
         5'd17: v = 32'h0000145F;
         5'd18: v = 32'h00000A2F;
         5'd19: v = 32'h00000517;
         5'd20: v = 32'h0000028B;
         5'd21: v = 32'h00000145;
         5'd22: v = 32'h000000A2;
         5'd23: v = 32'h00000051;
         5'd24: v = 32'h00000028;
         5'd25: v = 32'h00000014;
         5'd26: v = 32'h0000000A;
         5'd27: v = 32'h00000005;
         5'd28: v = 32'h00000002;
         5'd29: v = 32'h00000001;
         default: v = 32'h00000000;
      endcase
      return v;
   endfunction

endpackage

[hw/rtl/diff_drive_wheel_odometry_core.sv]
// Dead-reckoning odometry for a differential-drive base. Each input transfer carries the two raw
// wheel encoder counters; each produces one result transfer with the x/y position, the heading,
// the half-heading quaternion pair and the two unwrapped count changes. The first transfer after
// reset only latches the counters. The block works on one item at a time: a later item runs the
// bit-serial multiplies for the wheel distances, the yaw gain and the position steps and two
// passes of the shared one-step-per-cycle CORDIC; the first item runs only the quaternion pass.
// A finished result waits in the output register while the next item is accepted. Configuration
// writes are taken at any time but should be made only while the block is idle.
module diff_drive_wheel_odometry_core #(
   parameter int CORDIC_STEPS = dd_odo_pkg::CORDIC_STEPS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [31:0]                           req_left_count,
   input  logic [31:0]                           req_right_count,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [47:0]                    rsp_pos_x,
   output logic signed [47:0]                    rsp_pos_y,
   output logic [31:0]                           rsp_heading_angle,
   output logic signed [31:0]                    rsp_quat_z,
   output logic signed [31:0]                    rsp_quat_w,
   output logic signed [32:0]                    rsp_left_delta,
   output logic signed [32:0]                    rsp_right_delta,
   input  logic                                  csr_wr_en,
   input  logic [dd_odo_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [dd_odo_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import dd_odo_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_DIST, S_DSUM, S_DMIX, S_YAW, S_HEAD, S_CINIT, S_CRUN, S_CFIN,
      S_PLOAD, S_POS, S_STEP, S_ACC, S_QOUT
   } state_type;

   state_type state_ff;

   logic [31:0] left_k_ff, right_k_ff;
   logic [39:0] yaw_gain_ff;

   logic        first_ff;
   logic [31:0] prev_left_ff, prev_right_ff, heading_ff;
   logic signed [47:0] acc_x_ff, acc_y_ff;
   logic signed [32:0] dl_ff, dr_ff;
   logic signed [48:0] dist_l_ff, dist_r_ff, mean_ff;
   logic signed [50:0] step_x_ff, step_y_ff;
   logic signed [31:0] cos_ff, sin_ff;
   logic        neg_x_ff, neg_y_ff, cord_q_ff;

   logic [79:0] acc_a_ff, acc_b_ff;
   logic [63:0] md_a_ff, md_b_ff;
   logic [39:0] mq_a_ff, mq_b_ff;
   logic [CNT_W-1:0] cnt_ff;

   logic signed [33:0] cx_ff, cy_ff, cz_ff;
   logic [1:0]  quad_ff;

   logic rsp_valid_ff;
   logic signed [47:0] out_x_ff, out_y_ff;
   logic [31:0] out_head_ff;
   logic signed [31:0] out_qz_ff, out_qw_ff;
   logic signed [32:0] out_dl_ff, out_dr_ff;

   // Input deltas, unwrapped.
   logic signed [32:0] dl_raw, dr_raw, dl_in, dr_in;
   logic [31:0] mag_l, mag_r;

   assign dl_raw = $signed({1'b0, req_left_count}) - $signed({1'b0, prev_left_ff});
   assign dr_raw = $signed({1'b0, req_right_count}) - $signed({1'b0, prev_right_ff});

   always_comb begin
      dl_in = dl_raw;
      if (dl_raw > UNWRAP_LIMIT) begin
         dl_in = dl_raw - $signed({1'b1, 32'd0});
      end else if (dl_raw < -UNWRAP_LIMIT) begin
         dl_in = dl_raw + $signed({1'b1, 32'd0});
      end
      dr_in = dr_raw;
      if (dr_raw > UNWRAP_LIMIT) begin
         dr_in = dr_raw - $signed({1'b1, 32'd0});
      end else if (dr_raw < -UNWRAP_LIMIT) begin
         dr_in = dr_raw + $signed({1'b1, 32'd0});
      end
   end

   logic [32:0] abs_l, abs_r;
   assign abs_l = dl_in[32] ? 33'(-dl_in) : 33'(dl_in);
   assign abs_r = dr_in[32] ? 33'(-dr_in) : 33'(dr_in);
   assign mag_l = abs_l[31:0];
   assign mag_r = abs_r[31:0];

   // Shift-add multipliers, one multiplier bit per cycle from the top.
   logic [79:0] acc_a_in, acc_b_in;
   assign acc_a_in = {acc_a_ff[78:0], 1'b0} + (mq_a_ff[39] ? {16'd0, md_a_ff} : 80'd0);
   assign acc_b_in = {acc_b_ff[78:0], 1'b0} + (mq_b_ff[39] ? {16'd0, md_b_ff} : 80'd0);

   // Wheel distance rounding.
   logic [63:0] rnd_a, rnd_b;
   logic signed [48:0] dist_l_in, dist_r_in;
   assign rnd_a = acc_a_ff[63:0] + 64'd32768;
   assign rnd_b = acc_b_ff[63:0] + 64'd32768;
   assign dist_l_in = dl_ff[32] ? -$signed({1'b0, rnd_a[63:16]}) : $signed({1'b0, rnd_a[63:16]});
   assign dist_r_in = dr_ff[32] ? -$signed({1'b0, rnd_b[63:16]}) : $signed({1'b0, rnd_b[63:16]});

   logic signed [49:0] dsum, ddiff, dsum_adj;
   logic signed [48:0] mean_in;
   assign dsum  = 50'(dist_l_ff) + 50'(dist_r_ff);
   assign ddiff = 50'(dist_r_ff) - 50'(dist_l_ff);
   assign dsum_adj = dsum[49] ? dsum + 50'sd1 : dsum;
   assign mean_in = 49'(dsum_adj >>> 1);

   // Heading update.
   logic [63:0] yaw_rnd;
   logic [31:0] heading_in;
   assign yaw_rnd = acc_a_ff[63:0] + 64'h8000_0000;
   assign heading_in = heading_ff + yaw_rnd[63:32];

   // CORDIC angle reduction and iteration.
   logic [31:0] cord_ang, ang_off, ang_res;
   logic [1:0]  quad_in;
   assign cord_ang = cord_q_ff ? {1'b0, heading_ff[31:1]} : heading_ff;
   assign ang_off  = cord_ang + 32'h2000_0000;
   assign quad_in  = ang_off[31:30];
   assign ang_res  = cord_ang - {quad_in, 30'd0};

   logic [4:0] step_idx;
   logic signed [33:0] cdx, cdy, cat;
   assign step_idx = cnt_ff[4:0];
   assign cdx = cy_ff >>> step_idx;
   assign cdy = cx_ff >>> step_idx;
   assign cat = $signed({2'b00, atan_entry(step_idx)});

   logic signed [33:0] rot_c, rot_s;
   logic signed [31:0] cos_in, sin_in;
   always_comb begin
      case (quad_ff)
         2'd0: begin
            rot_c = cx_ff;
            rot_s = cy_ff;
         end
         2'd1: begin
            rot_c = -cy_ff;
            rot_s = cx_ff;
         end
         2'd2: begin
            rot_c = -cx_ff;
            rot_s = -cy_ff;
         end
         default: begin
            rot_c = cy_ff;
            rot_s = -cx_ff;
         end
      endcase
      if (rot_c > Q30_ONE) begin
         cos_in = 32'(Q30_ONE);
      end else if (rot_c < -Q30_ONE) begin
         cos_in = 32'(-Q30_ONE);
      end else begin
         cos_in = 32'(rot_c);
      end
      if (rot_s > Q30_ONE) begin
         sin_in = 32'(Q30_ONE);
      end else if (rot_s < -Q30_ONE) begin
         sin_in = 32'(-Q30_ONE);
      end else begin
         sin_in = 32'(rot_s);
      end
   end

   // Position step operands and results.
   logic [48:0] mean_mag;
   logic [31:0] cos_mag, sin_mag;
   assign mean_mag = mean_ff[48] ? 49'(-mean_ff) : 49'(mean_ff);
   assign cos_mag  = cos_ff[31] ? 32'(-cos_ff) : 32'(cos_ff);
   assign sin_mag  = sin_ff[31] ? 32'(-sin_ff) : 32'(sin_ff);

   logic [79:0] prnd_a, prnd_b;
   logic signed [50:0] step_x_in, step_y_in;
   assign prnd_a = acc_a_ff + 80'h2000_0000;
   assign prnd_b = acc_b_ff + 80'h2000_0000;
   assign step_x_in = neg_x_ff ? -$signed({1'b0, prnd_a[79:30]}) : $signed({1'b0, prnd_a[79:30]});
   assign step_y_in = neg_y_ff ? -$signed({1'b0, prnd_b[79:30]}) : $signed({1'b0, prnd_b[79:30]});

   logic signed [51:0] sum_x, sum_y;
   logic signed [47:0] acc_x_in, acc_y_in;
   assign sum_x = 52'(acc_x_ff) + 52'(step_x_ff);
   assign sum_y = 52'(acc_y_ff) + 52'(step_y_ff);
   assign acc_x_in = (sum_x > POS_MAX) ? 48'(POS_MAX) : (sum_x < POS_MIN) ? 48'(POS_MIN) : 48'(sum_x);
   assign acc_y_in = (sum_y > POS_MAX) ? 48'(POS_MAX) : (sum_y < POS_MIN) ? 48'(POS_MIN) : 48'(sum_y);

   assign req_ready = (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         left_k_ff   <= '0;
         right_k_ff  <= '0;
         yaw_gain_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_LEFT_DIST:  left_k_ff   <= csr_wdata[31:0];
            CSR_RIGHT_DIST: right_k_ff  <= csr_wdata[31:0];
            CSR_YAW_GAIN:   yaw_gain_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         first_ff      <= 1'b1;
         prev_left_ff  <= '0;
         prev_right_ff <= '0;
         heading_ff    <= '0;
         acc_x_ff      <= '0;
         acc_y_ff      <= '0;
         cnt_ff        <= '0;
         cord_q_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready && state_ff != S_QOUT) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  prev_left_ff  <= req_left_count;
                  prev_right_ff <= req_right_count;
                  first_ff      <= 1'b0;
                  cnt_ff        <= '0;
                  acc_a_ff      <= '0;
                  acc_b_ff      <= '0;
                  md_a_ff       <= {32'd0, left_k_ff};
                  md_b_ff       <= {32'd0, right_k_ff};
                  mq_a_ff       <= {mag_l, 8'd0};
                  mq_b_ff       <= {mag_r, 8'd0};
                  if (first_ff) begin
                     dl_ff     <= '0;
                     dr_ff     <= '0;
                     cord_q_ff <= 1'b1;
                     state_ff  <= S_CINIT;
                  end else begin
                     dl_ff     <= dl_in;
                     dr_ff     <= dr_in;
                     cord_q_ff <= 1'b0;
                     state_ff  <= S_DIST;
                  end
               end
            end
            S_DIST: begin
               acc_a_ff <= acc_a_in;
               acc_b_ff <= acc_b_in;
               mq_a_ff  <= {mq_a_ff[38:0], 1'b0};
               mq_b_ff  <= {mq_b_ff[38:0], 1'b0};
               cnt_ff   <= cnt_ff + 1'b1;
               if (cnt_ff == CNT_W'(31)) begin
                  state_ff <= S_DSUM;
               end
            end
            S_DSUM: begin
               dist_l_ff <= dist_l_in;
               dist_r_ff <= dist_r_in;
               state_ff  <= S_DMIX;
            end
            S_DMIX: begin
               mean_ff  <= mean_in;
               acc_a_ff <= '0;
               md_a_ff  <= 64'(ddiff);
               mq_a_ff  <= yaw_gain_ff;
               cnt_ff   <= '0;
               state_ff <= S_YAW;
            end
            S_YAW: begin
               acc_a_ff <= acc_a_in;
               mq_a_ff  <= {mq_a_ff[38:0], 1'b0};
               cnt_ff   <= cnt_ff + 1'b1;
               if (cnt_ff == CNT_W'(39)) begin
                  state_ff <= S_HEAD;
               end
            end
            S_HEAD: begin
               heading_ff <= heading_in;
               state_ff   <= S_CINIT;
            end
            S_CINIT: begin
               cx_ff    <= CORDIC_GAIN;
               cy_ff    <= '0;
               cz_ff    <= 34'($signed(ang_res));
               quad_ff  <= quad_in;
               cnt_ff   <= '0;
               state_ff <= S_CRUN;
            end
            S_CRUN: begin
               if (!cz_ff[33]) begin
                  cx_ff <= cx_ff - cdx;
                  cy_ff <= cy_ff + cdy;
                  cz_ff <= cz_ff - cat;
               end else begin
                  cx_ff <= cx_ff + cdx;
                  cy_ff <= cy_ff - cdy;
                  cz_ff <= cz_ff + cat;
               end
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == CNT_W'(CORDIC_STEPS - 1)) begin
                  state_ff <= S_CFIN;
               end
            end
            S_CFIN: begin
               cos_ff   <= cos_in;
               sin_ff   <= sin_in;
               state_ff <= cord_q_ff ? S_QOUT : S_PLOAD;
            end
            S_PLOAD: begin
               acc_a_ff <= '0;
               acc_b_ff <= '0;
               md_a_ff  <= {15'd0, mean_mag};
               md_b_ff  <= {15'd0, mean_mag};
               mq_a_ff  <= {cos_mag[30:0], 9'd0};
               mq_b_ff  <= {sin_mag[30:0], 9'd0};
               neg_x_ff <= mean_ff[48] ^ cos_ff[31];
               neg_y_ff <= mean_ff[48] ^ sin_ff[31];
               cnt_ff   <= '0;
               state_ff <= S_POS;
            end
            S_POS: begin
               acc_a_ff <= acc_a_in;
               acc_b_ff <= acc_b_in;
               mq_a_ff  <= {mq_a_ff[38:0], 1'b0};
               mq_b_ff  <= {mq_b_ff[38:0], 1'b0};
               cnt_ff   <= cnt_ff + 1'b1;
               if (cnt_ff == CNT_W'(30)) begin
                  state_ff <= S_STEP;
               end
            end
            S_STEP: begin
               step_x_ff <= step_x_in;
               step_y_ff <= step_y_in;
               state_ff  <= S_ACC;
            end
            S_ACC: begin
               acc_x_ff  <= acc_x_in;
               acc_y_ff  <= acc_y_in;
               cord_q_ff <= 1'b1;
               state_ff  <= S_CINIT;
            end
            S_QOUT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  out_x_ff     <= acc_x_ff;
                  out_y_ff     <= acc_y_ff;
                  out_head_ff  <= heading_ff;
                  out_qz_ff    <= sin_ff;
                  out_qw_ff    <= cos_ff;
                  out_dl_ff    <= dl_ff;
                  out_dr_ff    <= dr_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pos_x         = out_x_ff;
   assign rsp_pos_y         = out_y_ff;
   assign rsp_heading_angle = out_head_ff;
   assign rsp_quat_z        = out_qz_ff;
   assign rsp_quat_w        = out_qw_ff;
   assign rsp_left_delta    = out_dl_ff;
   assign rsp_right_delta   = out_dr_ff;

`ifndef NO_ASSERTIONS
   a_quat_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_quat_w <= 32'sd1073741824 && rsp_quat_w >= -32'sd1073741824 &&
                     rsp_quat_z <= 32'sd1073741824 && rsp_quat_z >= -32'sd1073741824))
      else $error("quaternion component out of range");

   a_rsp_from_qout: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_QOUT))
      else $error("result raised outside the output state");

   a_first_skip: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && first_ff) |=> (state_ff == S_CINIT && cord_q_ff))
      else $error("first transfer did not go straight to the quaternion pass");
`endif

endmodule

[dv/odometry_checker.sv]
module odometry_checker
   import dd_odo_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [31:0]        req_left_count,
   input  logic [31:0]        req_right_count,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic signed [47:0] rsp_pos_x,
   input  logic signed [47:0] rsp_pos_y,
   input  logic [31:0]        rsp_heading_angle,
   input  logic signed [31:0] rsp_quat_z,
   input  logic signed [31:0] rsp_quat_w,
   input  logic signed [32:0] rsp_left_delta,
   input  logic signed [32:0] rsp_right_delta,
   input  logic               csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                 fail_count,
   output int                 pending_poses,
   output int                 checked_poses
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint WRAP_SPAN = 64'sd4294967296;
   localparam longint UNWRAP_MAX = 64'sd1048576000;
   localparam longint GAIN_START = 64'sd652032874;
   localparam longint UNIT_Q30 = 64'sd1073741824;
   localparam longint SAT_HIGH = 64'sd140737488355327;
   localparam longint SAT_LOW = -64'sd140737488355328;
   localparam bit [31:0] ARCTAN [32] = '{
      32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
      32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C, 32'h000028BE, 32'h0000145F,
      32'h00000A2F, 32'h00000517, 32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
      32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001,
      32'h00000000, 32'h00000000};

   typedef struct {
      bit [47:0] pos_x;
      bit [47:0] pos_y;
      bit [31:0] heading;
      bit [31:0] quat_z;
      bit [31:0] quat_w;
      bit [32:0] left_delta;
      bit [32:0] right_delta;
   } pose_type;

   pose_type   pose_fifo[$];
   bit         awaiting_first;
   bit [31:0]  last_left;
   bit [31:0]  last_right;
   bit [31:0]  heading_acc;
   longint     x_acc;
   longint     y_acc;
   bit [31:0]  left_scale;
   bit [31:0]  right_scale;
   bit [39:0]  yaw_scale;

   assign pending_poses = pose_fifo.size();

   function automatic longint clamp_unit(longint v);
      if (v > UNIT_Q30) return UNIT_Q30;
      if (v < -UNIT_Q30) return -UNIT_Q30;
      return v;
   endfunction

   function automatic void rotate(input bit [31:0] angle, output longint c, output longint s);
      bit [31:0] quad;
      bit [31:0] resid;
      longint z;
      longint x;
      longint y;
      longint dx;
      longint dy;
      int k;
      quad = (angle + 32'h20000000) >> 30;
      resid = angle - (quad << 30);
      z = resid[31] ? longint'({32'd0, resid}) - WRAP_SPAN : longint'({32'd0, resid});
      x = GAIN_START;
      y = 0;
      for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
         k = i % 32;
         dx = y >>> k;
         dy = x >>> k;
         if (z >= 0) begin
            x = x - dx;
            y = y + dy;
            z = z - longint'({32'd0, ARCTAN[k]});
         end else begin
            x = x + dx;
            y = y - dy;
            z = z + longint'({32'd0, ARCTAN[k]});
         end
      end
      case (quad[1:0])
         2'd0: begin c = x;  s = y;  end
         2'd1: begin c = -y; s = x;  end
         2'd2: begin c = -x; s = -y; end
         default: begin c = y; s = -x; end
      endcase
      c = clamp_unit(c);
      s = clamp_unit(s);
   endfunction

   function automatic longint unwrap_count(bit [31:0] cur, bit [31:0] prev);
      longint d;
      d = longint'({32'd0, cur}) - longint'({32'd0, prev});
      if (d > UNWRAP_MAX) d = d - WRAP_SPAN;
      else if (d < -UNWRAP_MAX) d = d + WRAP_SPAN;
      return d;
   endfunction

   function automatic longint wheel_travel(longint d, bit [31:0] scale);
      bit [63:0] mag;
      bit [63:0] r;
      mag = (d < 0) ? -d : d;
      r = (mag * {32'd0, scale} + 64'd32768) >> 16;
      return (d < 0) ? -longint'(r) : longint'(r);
   endfunction

   function automatic longint scale_q30(longint m, longint c);
      bit neg;
      bit [63:0] um;
      bit [63:0] uc;
      bit [63:0] hi;
      bit [63:0] lo;
      bit [63:0] r;
      neg = (m < 0) != (c < 0);
      um = (m < 0) ? -m : m;
      uc = (c < 0) ? -c : c;
      hi = (um >> 24) * uc;
      lo = (um & 64'hFFFFFF) * uc;
      r = (hi >> 6) + ((((hi & 64'd63) << 24) + lo + 64'h20000000) >> 30);
      return neg ? -longint'(r) : longint'(r);
   endfunction

   function automatic longint saturate_pos(longint v);
      if (v > SAT_HIGH) return SAT_HIGH;
      if (v < SAT_LOW) return SAT_LOW;
      return v;
   endfunction

   function void predict_pose(bit [31:0] left_count, bit [31:0] right_count);
      pose_type p;
      longint dl;
      longint dr;
      longint sl;
      longint sr;
      longint mean;
      longint c;
      longint s;
      bit [63:0] turn;
      dl = 0;
      dr = 0;
      if (awaiting_first) begin
         awaiting_first = 0;
      end else begin
         dl = unwrap_count(left_count, last_left);
         dr = unwrap_count(right_count, last_right);
         sl = wheel_travel(dl, left_scale);
         sr = wheel_travel(dr, right_scale);
         mean = (sl + sr) / 2;
         turn = 64'(sr - sl) * {24'd0, yaw_scale} + 64'h80000000;
         heading_acc = heading_acc + turn[63:32];
         rotate(heading_acc, c, s);
         x_acc = saturate_pos(x_acc + scale_q30(mean, c));
         y_acc = saturate_pos(y_acc + scale_q30(mean, s));
      end
      last_left = left_count;
      last_right = right_count;
      rotate(heading_acc >> 1, c, s);
      p.pos_x = x_acc[47:0];
      p.pos_y = y_acc[47:0];
      p.heading = heading_acc;
      p.quat_z = s[31:0];
      p.quat_w = c[31:0];
      p.left_delta = dl[32:0];
      p.right_delta = dr[32:0];
      pose_fifo = {pose_fifo, p};
   endfunction

   task automatic compare_field(string field, bit [47:0] want, bit [47:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      pose_type e;
      if (reset) begin
         pose_fifo.delete();
         fail_count = 0;
         checked_poses = 0;
         awaiting_first = 1;
         last_left = 0;
         last_right = 0;
         heading_acc = 0;
         x_acc = 0;
         y_acc = 0;
         left_scale = 0;
         right_scale = 0;
         yaw_scale = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pose_fifo.size() == 0) begin
               $display("%0t: result transfer with no expected pose", $time);
               fail_count++;
            end else begin
               e = pose_fifo.pop_front();
               checked_poses++;
               compare_field("pos_x", e.pos_x, $unsigned(rsp_pos_x));
               compare_field("pos_y", e.pos_y, $unsigned(rsp_pos_y));
               compare_field("heading_angle", e.heading, rsp_heading_angle);
               compare_field("quat_z", e.quat_z, $unsigned(rsp_quat_z));
               compare_field("quat_w", e.quat_w, $unsigned(rsp_quat_w));
               compare_field("left_delta", e.left_delta, $unsigned(rsp_left_delta));
               compare_field("right_delta", e.right_delta, $unsigned(rsp_right_delta));
            end
         end
         if (req_valid && req_ready) predict_pose(req_left_count, req_right_count);
         if (csr_wr_en) begin
            case (csr_index)
               CSR_LEFT_DIST:  left_scale = csr_wdata[31:0];
               CSR_RIGHT_DIST: right_scale = csr_wdata[31:0];
               CSR_YAW_GAIN:   yaw_scale = csr_wdata[39:0];
               default: ;
            endcase
         end
      end
   end
endmodule

[dv/testbench.sv]
module testbench;
   import dd_odo_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;
   localparam int IDLE_LIMIT = 20000;
   localparam int SETTLE_CYCLES = 250;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [31:0]        req_left_count;
   logic [31:0]        req_right_count;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [47:0] rsp_pos_x;
   logic signed [47:0] rsp_pos_y;
   logic [31:0]        rsp_heading_angle;
   logic signed [31:0] rsp_quat_z;
   logic signed [31:0] rsp_quat_w;
   logic signed [32:0] rsp_left_delta;
   logic signed [32:0] rsp_right_delta;
   logic               csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int fail_count;
   int pending_poses;
   int checked_poses;
   int sent_items;
   int idle_cycles;
   int ready_gap;
   bit calm;
   bit [31:0] left_pos;
   bit [31:0] right_pos;

   diff_drive_wheel_odometry_core dut (.*);

   odometry_checker checker_i (.*);

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   initial begin
      rsp_ready = 0;
      forever begin
         @(negedge clock);
         ready_gap = calm ? 0 : $urandom_range(0, 14);
         if (ready_gap > 0) begin
            rsp_ready <= 0;
            repeat (ready_gap) @(negedge clock);
         end
         rsp_ready <= 1;
         @(posedge clock);
         while (!(rsp_valid && rsp_ready)) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_wr_en <= 1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_wr_en <= 0;
   endtask

   task automatic send_counts(bit [31:0] left_count, bit [31:0] right_count);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 14);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1;
      req_left_count <= left_count;
      req_right_count <= right_count;
      left_pos = left_count;
      right_pos = right_count;
      sent_items++;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic step_by(longint dl, longint dr);
      send_counts(left_pos + 32'(dl), right_pos + 32'(dr));
   endtask

   task automatic drain;
      @(negedge clock);
      req_valid <= 0;
      while (pending_poses != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_scales(bit [31:0] lk, bit [31:0] rk, bit [39:0] yk);
      write_csr(CSR_LEFT_DIST, {8'd0, lk});
      write_csr(CSR_RIGHT_DIST, {8'd0, rk});
      write_csr(CSR_YAW_GAIN, yk);
   endtask

   function automatic longint random_step();
      int kind;
      longint mag;
      kind = $urandom_range(0, 19);
      if (kind < 13) mag = $urandom_range(0, 5000);
      else if (kind < 15) mag = $urandom_range(1048575990, 1048576010);
      else if (kind < 17) mag = $urandom_range(0, 32'hFFFFFFFF);
      else if (kind < 19) mag = $urandom_range(0, 2000000);
      else mag = 0;
      return $urandom_range(0, 1) ? -mag : mag;
   endfunction

   task automatic random_run(int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 24) == 0) send_counts($urandom, $urandom);
         else step_by(random_step(), random_step());
      end
   endtask

   initial begin
      sent_items = 0;
      calm = 0;
      reset = 1;
      req_valid = 0;
      req_left_count = 0;
      req_right_count = 0;
      csr_wr_en = 0;
      csr_index = CSR_LEFT_DIST;
      csr_wdata = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 0;

      set_scales(32'd110000000, 32'd110500000, 40'd350000000000);
      send_counts(32'hFFFFFFFF, 32'h00000000);
      step_by(0, 0);
      step_by(1, -1);
      step_by(1048576000, -1048576000);
      step_by(1048576001, -1048576001);
      step_by(-1048576000, 1048576000);
      step_by(-1048576001, 1048576001);
      send_counts(32'h00000000, 32'hFFFFFFFF);
      send_counts(32'hFFFFFFFF, 32'h00000000);
      send_counts(32'h80000000, 32'h7FFFFFFF);
      for (int i = 0; i < 6; i++) step_by(-400000, 400000);
      drain();

      set_scales(32'hFFFFFFFF, 32'hFFFFFFFF, 40'hFFFFFFFFFF);
      write_csr(CSR_SPARE, 40'hFFFFFFFFFF);
      step_by(1048576000, 1048576000);
      step_by(1048576000, 1048576000);
      step_by(-1048576000, -1048576000);
      step_by(-1048576000, -1048576000);
      step_by(-1048576000, -1048576000);
      step_by(1048576000, 1048575000);
      random_run(150);
      drain();

      set_scales(32'd0, 32'd0, 40'd0);
      random_run(100);
      drain();

      set_scales($urandom, $urandom, {8'($urandom_range(0, 255)), $urandom});
      calm = 1;
      random_run(120);
      calm = 0;
      random_run(80);
      drain();

      set_scales($urandom_range(50000000, 200000000), $urandom_range(50000000, 200000000),
                 {8'd0, $urandom} * 40'd100);
      random_run(200);
      drain();

      set_scales($urandom_range(0, 65535), $urandom_range(0, 65535), {$urandom, 8'hFF});
      random_run(200);
      drain();

      $display("Sent %0d encoder samples over six scale settings; %0d poses checked.",
               sent_items, checked_poses);
      if (fail_count == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end
endmodule
